>>> rtl/core/bpc_pkg.sv
// Package for the barometric compensation core: field widths, register
// indexes, calibration word struct and the constants of the datapath.
// No dependencies.
`default_nettype none

package bpc_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int TEMP_W  = 18;
    localparam int PRES_W  = 24;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_SENS     = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFF      = 3'd1;
    localparam logic [IDX_W-1:0] REG_SENS_TC  = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFF_TC   = 3'd3;
    localparam logic [IDX_W-1:0] REG_REF_TEMP = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEMP_SNS = 3'd5;

    // Temperature base in hundredths of a degree
    localparam logic signed [19:0] TEMP_BASE = 20'sd2000;

    // Output clamp limits
    localparam logic signed [19:0] TEMP_MAX = 20'sd131071;
    localparam logic signed [19:0] TEMP_MIN = -20'sd131072;
    localparam logic signed [24:0] PRES_MAX = 25'sd8388607;
    localparam logic signed [24:0] PRES_MIN = -25'sd8388608;

    // Calibration words
    typedef struct packed {
        logic [COEF_W-1:0] sens;      // C1
        logic [COEF_W-1:0] off;       // C2
        logic [COEF_W-1:0] sens_tc;   // C3
        logic [COEF_W-1:0] off_tc;    // C4
        logic [COEF_W-1:0] ref_temp;  // C5
        logic [COEF_W-1:0] temp_sns;  // C6
    } t_coef;

endpackage

`default_nettype wire

>>> rtl/core/bpc_datapath.sv
// Six-stage compensation pipeline for the barometric compensation core.
// Depends on bpc_pkg for widths, clamp limits and the calibration struct.
`default_nettype none

module bpc_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bpc_pkg::t_coef              i_coef,
    input  wire logic                        i_s_valid,
    output logic                             o_s_ready,
    input  wire logic [bpc_pkg::RAW_W-1:0]   i_d1,
    input  wire logic [bpc_pkg::RAW_W-1:0]   i_d2,
    output logic                             o_m_valid,
    input  wire logic                        i_m_ready,
    output logic [bpc_pkg::TEMP_W-1:0]       o_temp,
    output logic [bpc_pkg::PRES_W-1:0]       o_pres,
    output logic                             o_sat
);

    localparam int NSTG = 6;

    // Stage valid bits and advance enables
    logic [NSTG:1]   r_vld;
    logic [NSTG+1:1] w_en;

    // Stage 1: dT
    logic [bpc_pkg::RAW_W-1:0] r_d1_1;
    logic signed [24:0]        r_dt, n_dt;
    // Stage 2: temperature products
    logic [bpc_pkg::RAW_W-1:0] r_d1_2;
    logic signed [41:0]        r_p_off, r_p_sens, r_p_temp;
    logic signed [41:0]        n_p_off, n_p_sens, n_p_temp;
    // Stage 3: OFF, SENS, TEMP
    logic [bpc_pkg::RAW_W-1:0] r_d1_3;
    logic signed [35:0]        r_off_3, r_sens, n_off, n_sens;
    logic signed [19:0]        r_temp_3, n_temp;
    // Stage 4: partial products of D1*SENS
    logic [41:0]               r_pp_lo, n_pp_lo;
    logic signed [41:0]        r_pp_hi, n_pp_hi;
    logic signed [35:0]        r_off_4;
    logic signed [19:0]        r_temp_4;
    // Stage 5: full product
    logic signed [59:0]        r_prod, n_prod;
    logic signed [35:0]        r_off_5;
    logic signed [19:0]        r_temp_5;
    // Stage 6: clamped results
    logic signed [39:0]        n_diff;
    logic signed [24:0]        n_pres_w;
    logic [bpc_pkg::TEMP_W-1:0] r_o_temp, n_o_temp;
    logic [bpc_pkg::PRES_W-1:0] r_o_pres, n_o_pres;
    logic                       r_o_sat, n_o_sat;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        w_en[NSTG+1] = i_m_ready;
        for (int k = NSTG; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_ready = w_en[1];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_s_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage arithmetic
    always_comb begin
        n_dt = $signed({1'b0, i_d2}) - $signed({1'b0, i_coef.ref_temp, 8'd0});

        n_p_off  = $signed({{17{r_dt[24]}}, r_dt}) * $signed({26'd0, i_coef.off_tc});
        n_p_sens = $signed({{17{r_dt[24]}}, r_dt}) * $signed({26'd0, i_coef.sens_tc});
        n_p_temp = $signed({{17{r_dt[24]}}, r_dt}) * $signed({26'd0, i_coef.temp_sns});

        // Floor divisions are arithmetic shifts, taken as part-selects
        n_off  = $signed({3'd0, i_coef.off, 17'd0}) + $signed(r_p_off[41:6]);
        n_sens = $signed({4'd0, i_coef.sens, 16'd0})
               + $signed({r_p_sens[41], r_p_sens[41:7]});
        n_temp = bpc_pkg::TEMP_BASE + $signed({r_p_temp[41], r_p_temp[41:23]});

        // Split D1*SENS on SENS bit 18
        n_pp_lo = {18'd0, r_d1_3} * {24'd0, r_sens[17:0]};
        n_pp_hi = $signed({18'd0, r_d1_3}) * $signed({{24{r_sens[35]}}, r_sens[35:18]});

        n_prod = $signed({r_pp_hi, 18'd0} + {18'd0, r_pp_lo});

        n_diff   = $signed({r_prod[59], r_prod[59:21]}) - $signed({{4{r_off_5[35]}}, r_off_5});
        n_pres_w = n_diff[39:15];

        // Clamp both results, flag either clamp
        n_o_sat = 1'b0;
        if (r_temp_5 > bpc_pkg::TEMP_MAX) begin
            n_o_temp = bpc_pkg::TEMP_MAX[bpc_pkg::TEMP_W-1:0];
            n_o_sat  = 1'b1;
        end else if (r_temp_5 < bpc_pkg::TEMP_MIN) begin
            n_o_temp = bpc_pkg::TEMP_MIN[bpc_pkg::TEMP_W-1:0];
            n_o_sat  = 1'b1;
        end else begin
            n_o_temp = r_temp_5[bpc_pkg::TEMP_W-1:0];
        end
        if (n_pres_w > bpc_pkg::PRES_MAX) begin
            n_o_pres = bpc_pkg::PRES_MAX[bpc_pkg::PRES_W-1:0];
            n_o_sat  = 1'b1;
        end else if (n_pres_w < bpc_pkg::PRES_MIN) begin
            n_o_pres = bpc_pkg::PRES_MIN[bpc_pkg::PRES_W-1:0];
            n_o_sat  = 1'b1;
        end else begin
            n_o_pres = n_pres_w[bpc_pkg::PRES_W-1:0];
        end
    end

    // Payload registers, each held while its stage stalls
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_d1_1 <= i_d1;
            r_dt   <= n_dt;
        end
        if (w_en[2]) begin
            r_d1_2   <= r_d1_1;
            r_p_off  <= n_p_off;
            r_p_sens <= n_p_sens;
            r_p_temp <= n_p_temp;
        end
        if (w_en[3]) begin
            r_d1_3   <= r_d1_2;
            r_off_3  <= n_off;
            r_sens   <= n_sens;
            r_temp_3 <= n_temp;
        end
        if (w_en[4]) begin
            r_pp_lo  <= n_pp_lo;
            r_pp_hi  <= n_pp_hi;
            r_off_4  <= r_off_3;
            r_temp_4 <= r_temp_3;
        end
        if (w_en[5]) begin
            r_prod   <= n_prod;
            r_off_5  <= r_off_4;
            r_temp_5 <= r_temp_4;
        end
        if (w_en[6]) begin
            r_o_temp <= n_o_temp;
            r_o_pres <= n_o_pres;
            r_o_sat  <= n_o_sat;
        end
    end

    assign o_m_valid = r_vld[NSTG];
    assign o_temp    = r_o_temp;
    assign o_pres    = r_o_pres;
    assign o_sat     = r_o_sat;

endmodule

`default_nettype wire

>>> rtl/core/barometric_pressure_compensation_core.sv
// Top level of the barometric compensation core: calibration registers on an
// APB port and the compensation pipeline. Depends on bpc_pkg and bpc_datapath.
`default_nettype none

// The core takes one word per clock while its output is not stalled and
// returns one word per input word, in order, through the six-stage
// pipeline: dT, the three temperature products, OFF/SENS/TEMP, the split
// D1*SENS partial products, their sum, and the final subtract and clamp.
// Stalls on the output hold every stage; an empty stage still takes a word.
// Calibration words are written through APB (C1..C6 at byte addresses
// 0x00..0x14) and must only be changed while no word is in flight.

module barometric_pressure_compensation_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Input stream
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [23:0] pressure_raw, [47:24] temperature_raw
    input  wire logic [47:0]                  i_s_axis_tdata,
    // Output stream
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    // [17:0] temperature_centi, [41:18] pressure_centi, [47:42] zero
    output logic [47:0]                       o_m_axis_tdata,
    // [0] saturated
    output logic                              o_m_axis_tuser,
    // APB configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bpc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bpc_pkg::DATA_W-1:0]   pwdata,
    output logic [bpc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    bpc_pkg::t_coef              r_coef;
    logic [bpc_pkg::IDX_W-1:0]   w_idx;
    logic                        w_wr;
    logic [bpc_pkg::COEF_W-1:0]  w_rd_word;
    logic [bpc_pkg::TEMP_W-1:0]  w_temp;
    logic [bpc_pkg::PRES_W-1:0]  w_pres;

    assign pready = 1'b1;
    assign w_idx  = paddr[bpc_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // Write calibration words; drop writes past the last register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                bpc_pkg::REG_SENS:     r_coef.sens     <= pwdata[bpc_pkg::COEF_W-1:0];
                bpc_pkg::REG_OFF:      r_coef.off      <= pwdata[bpc_pkg::COEF_W-1:0];
                bpc_pkg::REG_SENS_TC:  r_coef.sens_tc  <= pwdata[bpc_pkg::COEF_W-1:0];
                bpc_pkg::REG_OFF_TC:   r_coef.off_tc   <= pwdata[bpc_pkg::COEF_W-1:0];
                bpc_pkg::REG_REF_TEMP: r_coef.ref_temp <= pwdata[bpc_pkg::COEF_W-1:0];
                bpc_pkg::REG_TEMP_SNS: r_coef.temp_sns <= pwdata[bpc_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back calibration words
    always_comb begin
        unique case (w_idx)
            bpc_pkg::REG_SENS:     w_rd_word = r_coef.sens;
            bpc_pkg::REG_OFF:      w_rd_word = r_coef.off;
            bpc_pkg::REG_SENS_TC:  w_rd_word = r_coef.sens_tc;
            bpc_pkg::REG_OFF_TC:   w_rd_word = r_coef.off_tc;
            bpc_pkg::REG_REF_TEMP: w_rd_word = r_coef.ref_temp;
            bpc_pkg::REG_TEMP_SNS: w_rd_word = r_coef.temp_sns;
            default:               w_rd_word = '0;
        endcase
    end

    assign prdata = {{(bpc_pkg::DATA_W-bpc_pkg::COEF_W){1'b0}}, w_rd_word};

    bpc_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_coef    (r_coef),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_d1      (i_s_axis_tdata[23:0]),
        .i_d2      (i_s_axis_tdata[47:24]),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_temp    (w_temp),
        .o_pres    (w_pres),
        .o_sat     (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {6'd0, w_pres, w_temp};

endmodule

`default_nettype wire

>>> rtl/core/bpc_checker.sv
// Port-level checks for the barometric compensation core, with the bind that
// attaches them to the top level. Depends on bpc_pkg.
`default_nettype none

module bpc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_s_axis_tready,
    input wire logic                        o_m_axis_tvalid,
    input wire logic                        i_m_axis_tready,
    input wire logic [47:0]                 o_m_axis_tdata,
    input wire logic                        o_m_axis_tuser,
    input wire logic                        psel,
    input wire logic                        penable,
    input wire logic                        pwrite,
    input wire logic [bpc_pkg::ADDR_W-1:0]  paddr,
    input wire logic [bpc_pkg::DATA_W-1:0]  pwdata,
    input wire logic [bpc_pkg::DATA_W-1:0]  prdata,
    input wire logic                        pready
);

    logic w_temp_edge, w_pres_edge;

    assign w_temp_edge = (o_m_axis_tdata[17:0] == 18'h1FFFF)
                      || (o_m_axis_tdata[17:0] == 18'h20000);
    assign w_pres_edge = (o_m_axis_tdata[41:18] == 24'h7FFFFF)
                      || (o_m_axis_tdata[41:18] == 24'h800000);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled output word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output word changed");

    // With the output empty, the input side takes a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // Saturation only when a field sits at a clamp limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> w_temp_edge || w_pres_edge)
        else $error("saturation flag without clamped field");

    // A written SENS calibration word (C1) reads back
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[4:2] == bpc_pkg::REG_SENS)
        ##1 psel && !pwrite && (paddr[4:2] == bpc_pkg::REG_SENS)
        |-> prdata == {16'd0, $past(pwdata[15:0])})
        else $error("calibration word read back wrong");

endmodule

bind barometric_pressure_compensation_core bpc_checker u_bpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
);

`default_nettype wire
